// ----- rtl/rsp_pkg.sv -----
// Shared types, constants and the microcode program of the rotated sine path generator.
// Depends on nothing; every other file of the block depends on it.
package rsp_pkg;

    typedef logic [15:0]        time_step_t;
    typedef logic signed [31:0] pos_t;
    typedef logic [7:0]         cfg_index_t;
    typedef logic [23:0]        cfg_data_t;

    localparam cfg_index_t REG_DIRECTION = 8'd0;
    localparam cfg_index_t REG_SPEED     = 8'd1;
    localparam cfg_index_t REG_AMPLITUDE = 8'd2;
    localparam cfg_index_t REG_FREQUENCY = 8'd3;

    localparam int unsigned ATAN_LEN = 30;
    localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE        = 4'd0;
    localparam step_t STEP_MUL_PHASE   = 4'd1;
    localparam step_t STEP_LOAD_PHASE  = 4'd2;
    localparam step_t STEP_ITER_PHASE  = 4'd3;
    localparam step_t STEP_FLIP_PHASE  = 4'd4;
    localparam step_t STEP_ALONG       = 4'd5;
    localparam step_t STEP_ACROSS      = 4'd6;
    localparam step_t STEP_ITER_DIR    = 4'd7;
    localparam step_t STEP_FLIP_DIR    = 4'd8;
    localparam step_t STEP_MUL_XA      = 4'd9;
    localparam step_t STEP_MUL_YC      = 4'd10;
    localparam step_t STEP_MUL_YA      = 4'd11;
    localparam step_t STEP_MUL_XC      = 4'd12;
    localparam step_t STEP_EMIT        = 4'd13;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_LOOP,
        SEQ_EMIT
    } seq_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_PHASE,
        MUL_ALONG,
        MUL_ACROSS,
        MUL_XA,
        MUL_YC,
        MUL_YA,
        MUL_XC
    } mul_t;

    typedef enum logic [2:0] {
        CORD_NONE,
        CORD_LOAD_PHASE,
        CORD_LOAD_DIR,
        CORD_ITER,
        CORD_FLIP
    } cord_t;

    typedef enum logic [1:0] {
        SAT_NONE,
        SAT_ALONG,
        SAT_ACROSS,
        SAT_PX
    } sat_t;

    typedef struct packed {
        seq_t  seq;
        mul_t  mul;
        cord_t cord;
        logic  acc_load;
        sat_t  sat;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w = '{seq: SEQ_NEXT, mul: MUL_NONE, cord: CORD_NONE, acc_load: 1'b0, sat: SAT_NONE};
        unique case (step)
            STEP_IDLE:       w.seq = SEQ_WAIT_IN;
            STEP_MUL_PHASE:  w.mul = MUL_PHASE;
            STEP_LOAD_PHASE: w.cord = CORD_LOAD_PHASE;
            STEP_ITER_PHASE:
            begin
                w.seq  = SEQ_LOOP;
                w.cord = CORD_ITER;
            end
            STEP_FLIP_PHASE:
            begin
                w.cord = CORD_FLIP;
                w.mul  = MUL_ALONG;
            end
            STEP_ALONG:
            begin
                w.sat = SAT_ALONG;
                w.mul = MUL_ACROSS;
            end
            STEP_ACROSS:
            begin
                w.sat  = SAT_ACROSS;
                w.cord = CORD_LOAD_DIR;
            end
            STEP_ITER_DIR:
            begin
                w.seq  = SEQ_LOOP;
                w.cord = CORD_ITER;
            end
            STEP_FLIP_DIR:   w.cord = CORD_FLIP;
            STEP_MUL_XA:     w.mul = MUL_XA;
            STEP_MUL_YC:
            begin
                w.acc_load = 1'b1;
                w.mul      = MUL_YC;
            end
            STEP_MUL_YA:
            begin
                w.sat = SAT_PX;
                w.mul = MUL_YA;
            end
            STEP_MUL_XC:
            begin
                w.acc_load = 1'b1;
                w.mul      = MUL_XC;
            end
            STEP_EMIT:       w.seq = SEQ_EMIT;
            default:         w.seq = SEQ_EMIT;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] a;
        unique case (idx)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458908;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667332;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340246;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    function automatic pos_t sat32(input logic signed [67:0] v);
        pos_t r;
        if ((v[67:31] == '0) || (v[67:31] == '1))
        begin
            r = v[31:0];
        end
        else if (v[67])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ----- rtl/rsp_tick_if.sv -----
// Input channel of the path generator: one time step per transfer.
// Depends on rsp_pkg.
interface rsp_tick_if;
    logic                valid;
    logic                ready;
    rsp_pkg::time_step_t time_step;

    modport source (output valid, output time_step, input ready);
    modport sink   (input valid, input time_step, output ready);
endinterface

// ----- rtl/rsp_pos_if.sv -----
// Result channel of the path generator: one rotated position per transfer.
// Depends on rsp_pkg.
interface rsp_pos_if;
    logic          valid;
    logic          ready;
    rsp_pkg::pos_t pos_x;
    rsp_pkg::pos_t pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

// ----- rtl/rsp_cfg_if.sv -----
// Configuration write channel of the path generator: register index and data.
// Depends on rsp_pkg.
interface rsp_cfg_if;
    logic                valid;
    logic                ready;
    rsp_pkg::cfg_index_t index;
    rsp_pkg::cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rotated_sine_path_generator_core.sv -----
// Rotated sine path generator: microcoded sequencer over one multiplier and one CORDIC stage.
// A new tick is taken only in the idle step, after the result of the last tick has been emitted;
// a stalled result holds the block. The two CORDIC passes share a single rotation stage
// and all products share the one multiplier.
// Reset clears configuration, elapsed time, microcode step counter and result valid; no clearing pass.
// Depends on rsp_pkg and the rsp_tick_if, rsp_pos_if and rsp_cfg_if interfaces.
module rotated_sine_path_generator_core #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rsp_tick_if.sink   tick,
    rsp_pos_if.source  result,
    rsp_cfg_if.sink    cfg
);
    import rsp_pkg::*;

    localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    step_t        pc_reg;
    step_t        pc_next;
    ctrl_t        uw;

    logic [15:0]  direction_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] amplitude_reg;
    logic [23:0]  frequency_reg;
    logic [31:0]  elapsed_reg;
    logic [15:0]  step_reg;

    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               flip_reg;

    logic signed [66:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic signed [31:0] along_reg;
    logic signed [31:0] across_reg;
    logic signed [31:0] px_reg;

    logic               out_valid_reg;
    pos_t               pos_x_reg;
    pos_t               pos_y_reg;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] prod_c;

    logic [31:0]        load_angle;
    logic signed [33:0] load_z;
    logic               load_flip;
    logic signed [33:0] x_shift;
    logic signed [33:0] y_shift;
    logic signed [33:0] atan_c;

    logic               tick_xfer;
    logic               emit_ok;
    logic               emit;
    logic [32:0]        elapsed_sum;

    assign uw        = ucode_rom(pc_reg);
    assign tick.ready = (pc_reg == STEP_IDLE);
    assign tick_xfer = tick.valid && tick.ready;
    assign emit_ok   = !out_valid_reg || result.ready;
    assign emit      = (uw.seq == SEQ_EMIT) && emit_ok;
    assign elapsed_sum = {1'b0, elapsed_reg} + {17'd0, step_reg};

    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.pos_x = pos_x_reg;
    assign result.pos_y = pos_y_reg;

    always_comb
    begin
        pc_next = pc_reg;
        unique case (uw.seq)
            SEQ_NEXT:    pc_next = pc_reg + 4'd1;
            SEQ_WAIT_IN: pc_next = tick.valid ? pc_reg + 4'd1 : pc_reg;
            SEQ_LOOP:    pc_next = (cnt_reg == CNT_LAST) ? pc_reg + 4'd1 : pc_reg;
            SEQ_EMIT:    pc_next = emit_ok ? STEP_IDLE : pc_reg;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (uw.mul)
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_PHASE:
            begin
                mul_a = $signed({10'd0, frequency_reg});
                mul_b = $signed({1'b0, elapsed_reg});
            end
            MUL_ALONG:
            begin
                mul_a = 34'(speed_reg);
                mul_b = $signed({1'b0, elapsed_reg});
            end
            MUL_ACROSS:
            begin
                mul_a = y_reg;
                mul_b = 33'(amplitude_reg);
            end
            MUL_XA:
            begin
                mul_a = x_reg;
                mul_b = 33'(along_reg);
            end
            MUL_YC:
            begin
                mul_a = y_reg;
                mul_b = 33'(across_reg);
            end
            MUL_YA:
            begin
                mul_a = y_reg;
                mul_b = 33'(along_reg);
            end
            MUL_XC:
            begin
                mul_a = x_reg;
                mul_b = 33'(across_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = 67'(mul_a) * 67'(mul_b);

    always_comb
    begin
        load_angle = (uw.cord == CORD_LOAD_DIR) ? {direction_reg, 16'd0} : prod_reg[31:0];
        load_z     = 34'($signed(load_angle));
        load_flip  = 1'b0;
        if (load_z > QUARTER_TURN)
        begin
            load_z    = load_z - HALF_TURN;
            load_flip = 1'b1;
        end
        else if (load_z < -QUARTER_TURN)
        begin
            load_z    = load_z + HALF_TURN;
            load_flip = 1'b1;
        end
    end

    assign x_shift = x_reg >>> cnt_reg;
    assign y_shift = y_reg >>> cnt_reg;
    assign atan_c  = $signed({2'b00, atan_turn(5'(cnt_reg))});

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            step_reg <= tick.time_step;
        end
        if (uw.mul != MUL_NONE)
        begin
            prod_reg <= prod_c;
        end
        if (uw.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        unique case (uw.sat)
            SAT_NONE:   ;
            SAT_ALONG:  along_reg  <= sat32(68'(prod_reg) >>> 8);
            SAT_ACROSS: across_reg <= sat32(68'(prod_reg) >>> 22);
            SAT_PX:     px_reg     <= sat32((68'(acc_reg) - 68'(prod_reg)) >>> 30);
        endcase
        unique case (uw.cord)
            CORD_NONE: ;
            CORD_LOAD_PHASE, CORD_LOAD_DIR:
            begin
                x_reg    <= GAIN_Q30;
                y_reg    <= '0;
                z_reg    <= load_z;
                flip_reg <= load_flip;
                cnt_reg  <= '0;
            end
            CORD_ITER:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - y_shift;
                    y_reg <= y_reg + x_shift;
                    z_reg <= z_reg - atan_c;
                end
                else
                begin
                    x_reg <= x_reg + y_shift;
                    y_reg <= y_reg - x_shift;
                    z_reg <= z_reg + atan_c;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            CORD_FLIP:
            begin
                if (flip_reg)
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                end
            end
            default: ;
        endcase
        if (emit)
        begin
            pos_x_reg <= px_reg;
            pos_y_reg <= sat32((68'(acc_reg) + 68'(prod_reg)) >>> 30);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_IDLE;
            out_valid_reg <= 1'b0;
            direction_reg <= '0;
            speed_reg     <= '0;
            amplitude_reg <= '0;
            frequency_reg <= '0;
            elapsed_reg   <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                elapsed_reg   <= elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_DIRECTION:
                    begin
                        direction_reg <= cfg.data[15:0];
                        elapsed_reg   <= '0;
                    end
                    REG_SPEED:
                    begin
                        speed_reg   <= $signed(cfg.data[15:0]);
                        elapsed_reg <= '0;
                    end
                    REG_AMPLITUDE:
                    begin
                        amplitude_reg <= $signed(cfg.data[15:0]);
                        elapsed_reg   <= '0;
                    end
                    REG_FREQUENCY:
                    begin
                        frequency_reg <= cfg.data;
                        elapsed_reg   <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/rsp_checker.sv -----
// Port-level checker for the rotated sine path generator, bound to the top level.
// Depends on rsp_pkg and on rotated_sine_path_generator_core.
module rsp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          tick_valid,
    input logic          tick_ready,
    input logic          res_valid,
    input logic          res_ready,
    input rsp_pkg::pos_t pos_x,
    input rsp_pkg::pos_t pos_y,
    input logic          cfg_ready
);
    import rsp_pkg::*;

    // A stalled result must hold its value until it is transferred.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(pos_x) && $stable(pos_y))
        else $error("result changed while stalled");

    // The block works on one tick at a time.
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick taken while another was in progress");

    // A new result never appears in the cycle right after a tick transfer.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !$rose(res_valid))
        else $error("result appeared too early");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind rotated_sine_path_generator_core rsp_checker u_rsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .pos_x      (result.pos_x),
    .pos_y      (result.pos_y),
    .cfg_ready  (cfg.ready)
);
